@@ rtl/kme_pkg.sv @@
// shared types, symbol constants and keypad decode functions for the multitap encoder
// used by every module of keypad_multitap_encoder; depends on nothing

package kme_pkg;

  localparam logic [7:0] SymHash  = 8'h23;  // '#'
  localparam logic [7:0] SymStar  = 8'h2A;  // '*'
  localparam logic [7:0] SymPause = 8'h7C;  // '|'
  localparam logic [7:0] SymZero  = 8'h30;  // '0'
  localparam logic [7:0] SymNone  = 8'h00;

  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef struct packed {
    logic [7:0] in_char;
    logic       start_req;
  } in_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       run_end;
  } out_word_t;

  // one classified character: optional '#' or '|' prefix, then cnt code symbols
  typedef struct packed {
    logic       pre_en;
    logic [7:0] pre_sym;
    logic [7:0] first_sym;
    logic [7:0] rest_sym;
    logic [2:0] cnt;
  } job_t;

  function automatic logic [7:0] key_of(input logic [4:0] off);
    logic [7:0] k;
    unique case (off) inside
      [5'd0:5'd2]:   k = 8'h32;
      [5'd3:5'd5]:   k = 8'h33;
      [5'd6:5'd8]:   k = 8'h34;
      [5'd9:5'd11]:  k = 8'h35;
      [5'd12:5'd14]: k = 8'h36;
      [5'd15:5'd18]: k = 8'h37;
      [5'd19:5'd21]: k = 8'h38;
      [5'd22:5'd25]: k = 8'h39;
      default:       k = SymNone;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] taps_of(input logic [4:0] off);
    logic [2:0] t;
    unique case (off) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd19, 5'd22: t = 3'd1;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd20, 5'd23: t = 3'd2;
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd21, 5'd24: t = 3'd3;
      5'd18, 5'd25:                                       t = 3'd4;
      default:                                            t = 3'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/keypad_multitap_encoder.sv @@
// top level of the phone keypad multitap encoder
// depends on kme_pkg, kme_front, kme_job_fifo and kme_back

// One ASCII character is pushed per word and comes out as zero to five keypad
// symbols, one per cycle as long as the output is popped, with run_end set on the
// last symbol of each character. The front end classifies a character and updates
// the case flag and last-symbol state in the cycle it is accepted, so characters
// are taken back to back until the job queue (JobDepth entries) fills. The output
// side delivers one symbol per cycle unless pop holds it back. A character gives
// one or two symbols for a space (a space after a '0' gets a '|' first), two for
// a digit, one to five for a letter; characters outside letters, digits and space
// produce no word.

module keypad_multitap_encoder #(
  parameter int JobDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  kme_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output kme_pkg::out_word_t out_word_o
);

  logic          accept;
  logic          job_valid;
  kme_pkg::job_t job_in, job_head;
  logic          job_empty, job_rd;

  assign accept = push && !full;

  kme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  kme_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_valid),
    .wr_data_i (job_in),
    .full_o    (full),
    .rd_i      (job_rd),
    .empty_o   (job_empty),
    .rd_data_o (job_head)
  );

  kme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_rd_o    (job_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/kme_front.sv @@
// front end: accepts characters, classifies them and keeps case flag and last symbol
// depends on kme_pkg

module kme_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  kme_pkg::in_word_t in_word_i,
  output logic            job_valid_o,
  output kme_pkg::job_t   job_o
);

  logic       upper_q, upper_d;
  logic [7:0] last_q, last_d;

  logic       eff_upper;
  logic [7:0] eff_last;
  logic [7:0] ch;
  logic       is_lower, is_upper, is_letter, is_digit, is_space, is_code;
  logic [4:0] off;
  logic       case_sw;
  logic       pause;
  logic [7:0] first_sym, rest_sym, final_sym;
  logic [2:0] cnt;
  logic [7:0] diff_lo, diff_up;

  always_comb begin
    ch        = in_word_i.in_char;
    eff_upper = in_word_i.start_req ? 1'b0 : upper_q;
    eff_last  = in_word_i.start_req ? kme_pkg::SymNone : last_q;

    is_lower  = (ch >= kme_pkg::ChLowerA) && (ch <= kme_pkg::ChLowerZ);
    is_upper  = (ch >= kme_pkg::ChUpperA) && (ch <= kme_pkg::ChUpperZ);
    is_digit  = (ch >= kme_pkg::ChDigit0) && (ch <= kme_pkg::ChDigit9);
    is_space  = (ch == kme_pkg::ChSpace);
    is_letter = is_lower || is_upper;
    is_code   = is_letter || is_digit || is_space;

    diff_lo = ch - kme_pkg::ChLowerA;
    diff_up = ch - kme_pkg::ChUpperA;
    off     = is_lower ? diff_lo[4:0] : diff_up[4:0];

    case_sw = (is_lower && eff_upper) || (is_upper && !eff_upper);

    if (is_letter) begin
      first_sym = kme_pkg::key_of(off);
      rest_sym  = first_sym;
      cnt       = kme_pkg::taps_of(off);
    end else if (is_digit) begin
      first_sym = kme_pkg::SymStar;
      rest_sym  = ch;
      cnt       = 3'd2;
    end else begin
      first_sym = kme_pkg::SymZero;
      rest_sym  = kme_pkg::SymZero;
      cnt       = 3'd1;
    end
    final_sym = (cnt > 3'd1) ? rest_sym : first_sym;

    // after a '#' no code can repeat the last symbol
    pause = !case_sw && (eff_last != kme_pkg::SymNone) && (first_sym == eff_last);

    upper_d = is_letter ? is_upper : eff_upper;
    last_d  = is_code ? final_sym : eff_last;

    job_valid_o     = accept_i && is_code;
    job_o.pre_en    = case_sw || pause;
    job_o.pre_sym   = case_sw ? kme_pkg::SymHash : kme_pkg::SymPause;
    job_o.first_sym = first_sym;
    job_o.rest_sym  = rest_sym;
    job_o.cnt       = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 1'b0;
      last_q  <= kme_pkg::SymNone;
    end else if (accept_i) begin
      upper_q <= upper_d;
      last_q  <= last_d;
    end
  end

endmodule

@@ rtl/kme_job_fifo.sv @@
// small queue of classified jobs between front end and symbol sequencer
// depends on kme_pkg

module kme_job_fifo #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  kme_pkg::job_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output kme_pkg::job_t rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  kme_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == DepthCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/kme_back.sv @@
// back end: steps one job a symbol per cycle into out_q unless pop stalls it
// depends on kme_pkg

module kme_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  input  kme_pkg::job_t      job_i,
  output logic               job_rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output kme_pkg::out_word_t out_word_o
);

  logic [2:0]         step_q, step_d;
  logic               out_valid_q, out_valid_d;
  kme_pkg::out_word_t out_q, out_d;
  logic [2:0]         total;
  logic               advance, emit, last;

  always_comb begin
    total   = job_i.cnt + {2'b00, job_i.pre_en};
    advance = !out_valid_q || pop_i;
    emit    = advance && !job_empty_i;
    last    = (step_q == total - 3'd1);

    if (job_i.pre_en && step_q == 3'd0) begin
      out_d.symbol = job_i.pre_sym;
    end else if ((job_i.pre_en && step_q == 3'd1) || (!job_i.pre_en && step_q == 3'd0)) begin
      out_d.symbol = job_i.first_sym;
    end else begin
      out_d.symbol = job_i.rest_sym;
    end
    out_d.run_end = last;

    step_d      = emit ? (last ? 3'd0 : step_q + 3'd1) : step_q;
    out_valid_d = emit ? 1'b1 : (advance ? 1'b0 : out_valid_q);
    job_rd_o    = emit && last;
  end

  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
